>>> hdl/bfe_pkg.sv
// Shared types, codes and constants of the Bloom filter engine.
// Used by the channel interfaces and by every module of the engine.
package bfe_pkg;

  // Default sizes of the store and of the hash fan-out.
  localparam int unsigned BIT_CAPACITY_DEF = 65536;
  localparam int unsigned MAX_HASHES_DEF   = 16;

  // Field and register widths.
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BCNT_W  = 17;
  localparam int unsigned HCNT_W  = 5;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 17;

  // Opcodes of an input item.
  localparam logic [OPC_W-1:0] OPC_ADD   = 2'd0;
  localparam logic [OPC_W-1:0] OPC_QUERY = 2'd1;
  localparam logic [OPC_W-1:0] OPC_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_BIT_COUNT  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HASH_COUNT = 2'd1;

  // Register reset values.
  localparam logic [BCNT_W-1:0] BIT_COUNT_RST  = 17'd65536;
  localparam logic [HCNT_W-1:0] HASH_COUNT_RST = 5'd3;

  // Mixing constants.
  localparam logic [HASH_W-1:0] MIX_SALT = 64'h0000_0000_9e37_79b9;
  localparam logic [31:0]       MIX_C1   = 32'h85eb_ca6b;
  localparam logic [31:0]       MIX_C2   = 32'hc2b2_ae35;
  localparam int unsigned       MIX_SH_A = 16;
  localparam int unsigned       MIX_SH_B = 13;

  // Remainder bits resolved per divider cycle.
  localparam int unsigned DIV_STEPS = 4;

  // Command class that the front end assigns to an item.
  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_QUERY,
    CMD_CLEAR,
    CMD_NOP
  } cmd_t;

  // One entry of the queue between front and back.
  typedef struct packed {
    cmd_t              cmd;
    logic [HASH_W-1:0] base;
  } q_entry_t;

  // Active configuration handed to the back end.
  typedef struct packed {
    logic [BCNT_W-1:0] bit_count;
    logic [HCNT_W-1:0] hash_count;
  } cfg_t;

  // Status the back end reports to the front end.
  typedef struct packed {
    logic init_busy;
  } back_status_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_PREP,
    ST_M1L,
    ST_M1H,
    ST_X13,
    ST_M2L,
    ST_M2H,
    ST_DLOAD,
    ST_DIV,
    ST_RD,
    ST_CHK,
    ST_SWEEP,
    ST_DONE
  } bstate_t;

endpackage

>>> hdl/bfe_in_if.sv
// Input channel of the Bloom filter engine: opcode and base hash.
// Depends on bfe_pkg for field widths.
interface bfe_in_if;
  logic                        valid;
  logic                        ready;
  logic [bfe_pkg::OPC_W-1:0]   opcode;
  logic [bfe_pkg::HASH_W-1:0]  base_hash;

  modport source (output valid, output opcode, output base_hash, input ready);
  modport sink (input valid, input opcode, input base_hash, output ready);
endinterface

>>> hdl/bfe_out_if.sv
// Result channel of the Bloom filter engine: query answer and add count.
// Depends on bfe_pkg for field widths.
interface bfe_out_if;
  logic                       valid;
  logic                       ready;
  logic                       might_contain;
  logic [bfe_pkg::CNT_W-1:0]  element_count;

  modport source (output valid, output might_contain, output element_count, input ready);
  modport sink (input valid, input might_contain, input element_count, output ready);
endinterface

>>> hdl/bfe_cfg_if.sv
// Configuration write channel of the Bloom filter engine.
// Depends on bfe_pkg for index and data widths.
interface bfe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bfe_pkg::CIDX_W-1:0]   reg_index;
  logic [bfe_pkg::CDATA_W-1:0]  data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

>>> hdl/bfe_front.sv
// Front end: accepts input items, classifies the opcode and queues them.
// Depends on bfe_pkg and bfe_in_if.
module bfe_front (
  input  logic                    clk,
  input  logic                    rst_n,
  bfe_in_if.sink                  in_ch,
  input  bfe_pkg::back_status_t   status,
  output logic                    q_valid,
  input  logic                    q_ready,
  output bfe_pkg::q_entry_t       q_entry
);

  // Two-entry queue held in registers.
  bfe_pkg::q_entry_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  bfe_pkg::cmd_t cmd_in;

  // Classify the opcode of the incoming item.
  always_comb begin
    unique case (in_ch.opcode)
      bfe_pkg::OPC_ADD:   cmd_in = bfe_pkg::CMD_ADD;
      bfe_pkg::OPC_QUERY: cmd_in = bfe_pkg::CMD_QUERY;
      bfe_pkg::OPC_CLEAR: cmd_in = bfe_pkg::CMD_CLEAR;
      default:            cmd_in = bfe_pkg::CMD_NOP;
    endcase
  end

  // No item is taken while the store is swept after reset.
  assign in_ch.ready = (fill_r != 2'd2) && !status.init_busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_entry     = q_mem_r[rd_ptr_r];

  // Queue pointer and fill updates.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{cmd: cmd_in, base: in_ch.base_hash};
    end
  end

endmodule

>>> hdl/bfe_back.sv
// Back end: derives the hash positions, reduces them modulo the bit count,
// accesses the bit store and delivers the result. Depends on bfe_pkg, bfe_out_if.
module bfe_back #(
  parameter int unsigned BIT_CAPACITY = bfe_pkg::BIT_CAPACITY_DEF,
  parameter int unsigned MAX_HASHES   = bfe_pkg::MAX_HASHES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bfe_pkg::cfg_t           cfg,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  bfe_pkg::q_entry_t       q_entry,
  output bfe_pkg::back_status_t   status,
  bfe_out_if.source               out_ch
);

  localparam int unsigned WORDS = (BIT_CAPACITY + 63) / 64;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned IW    = $clog2(BIT_CAPACITY);
  localparam int unsigned KW    = $clog2(MAX_HASHES + 1);
  localparam int unsigned NW    = bfe_pkg::BCNT_W;
  localparam int unsigned HW    = bfe_pkg::HASH_W;
  localparam int unsigned DCW   = $clog2(HW / bfe_pkg::DIV_STEPS);

  bfe_pkg::bstate_t state_r, state_nxt;

  // Datapath registers.
  bfe_pkg::cmd_t         cmd_r;
  logic [HW-1:0]         base_r;
  logic [HW-1:0]         salt_r;
  logic [HW-1:0]         x_r;
  logic [HW-1:0]         plo_r;
  logic [HW-1:0]         dq_r;
  logic [NW-1:0]         rem_r;
  logic [DCW-1:0]        dcnt_r;
  logic [KW-1:0]         hidx_r;
  logic [AW-1:0]         sw_addr_r;
  logic                  hit_r;
  logic [bfe_pkg::CNT_W-1:0] cnt_r;
  logic [63:0]           rdata_r;

  // Output register.
  logic                  out_vld_r;
  logic                  out_hit_r;
  logic [bfe_pkg::CNT_W-1:0] out_cnt_r;

  // Bit store, 64 bits a word.
  logic [63:0] mem [WORDS];

  // Control outputs.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic          q_pop;
  logic          res_load;
  logic          out_free;

  // Effective divisor and hash count.
  logic [NW-1:0] n_use;
  logic [KW-1:0] k_use;

  always_comb begin
    if (cfg.bit_count == '0) begin
      n_use = NW'(1);
    end else if (32'(cfg.bit_count) > 32'(BIT_CAPACITY)) begin
      n_use = NW'(BIT_CAPACITY);
    end else begin
      n_use = cfg.bit_count;
    end
    if (32'(cfg.hash_count) > 32'(MAX_HASHES)) begin
      k_use = KW'(MAX_HASHES);
    end else begin
      k_use = KW'(cfg.hash_count);
    end
  end

  // Shared 32 by 32 multiplier for both halves of both mixing products.
  logic [31:0] mul_a, mul_c;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = ((state_r == bfe_pkg::ST_M1L) || (state_r == bfe_pkg::ST_M2L)) ?
            x_r[31:0] : x_r[63:32];
    mul_c = ((state_r == bfe_pkg::ST_M1L) || (state_r == bfe_pkg::ST_M1H)) ?
            bfe_pkg::MIX_C1 : bfe_pkg::MIX_C2;
    mul_p = mul_a * mul_c;
  end

  // Salted base: the base hash xor the running salt; the first xor-shift is applied in the prep state.
  logic [HW-1:0] salted;
  assign salted = base_r ^ salt_r;

  // Divider: several restoring steps per cycle on the remainder.
  logic [NW-1:0] rem_step;
  logic [HW-1:0] dq_step;

  always_comb begin
    logic [NW:0] t;
    rem_step = rem_r;
    dq_step  = dq_r;
    for (int j = 0; j < int'(bfe_pkg::DIV_STEPS); j++) begin
      t       = {rem_step, dq_step[HW-1]};
      dq_step = {dq_step[HW-2:0], 1'b0};
      if (t >= {1'b0, n_use}) begin
        rem_step = NW'(t - {1'b0, n_use});
      end else begin
        rem_step = t[NW-1:0];
      end
    end
  end

  // Bit position and word address from the remainder.
  logic [IW+NW-1:0] idx_ext;
  logic [IW-1:0]    idx;
  logic [IW+AW-1:0] addr_ext;
  logic [AW-1:0]    word_addr;
  logic [5:0]       bit_pos;
  logic             bit_set;
  logic             last_hash;

  always_comb begin
    idx_ext   = {{IW{1'b0}}, rem_r};
    idx       = idx_ext[IW-1:0];
    addr_ext  = {{AW{1'b0}}, idx} >> 6;
    word_addr = addr_ext[AW-1:0];
    bit_pos   = idx[5:0];
    bit_set   = rdata_r[bit_pos];
    last_hash = ((hidx_r + KW'(1)) == k_use);
  end

  assign out_free = !out_vld_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfe_pkg::ST_INIT_CLR: begin
        if (sw_addr_r == AW'(WORDS - 1)) state_nxt = bfe_pkg::ST_IDLE;
      end
      bfe_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.cmd) inside
            bfe_pkg::CMD_ADD, bfe_pkg::CMD_QUERY:
              state_nxt = (k_use == '0) ? bfe_pkg::ST_DONE : bfe_pkg::ST_PREP;
            bfe_pkg::CMD_CLEAR: state_nxt = bfe_pkg::ST_SWEEP;
            default:            state_nxt = bfe_pkg::ST_DONE;
          endcase
        end
      end
      bfe_pkg::ST_PREP:  state_nxt = bfe_pkg::ST_M1L;
      bfe_pkg::ST_M1L:   state_nxt = bfe_pkg::ST_M1H;
      bfe_pkg::ST_M1H:   state_nxt = bfe_pkg::ST_X13;
      bfe_pkg::ST_X13:   state_nxt = bfe_pkg::ST_M2L;
      bfe_pkg::ST_M2L:   state_nxt = bfe_pkg::ST_M2H;
      bfe_pkg::ST_M2H:   state_nxt = bfe_pkg::ST_DLOAD;
      bfe_pkg::ST_DLOAD: state_nxt = bfe_pkg::ST_DIV;
      bfe_pkg::ST_DIV: begin
        if (dcnt_r == '1) state_nxt = bfe_pkg::ST_RD;
      end
      bfe_pkg::ST_RD: state_nxt = bfe_pkg::ST_CHK;
      bfe_pkg::ST_CHK: begin
        if (last_hash || ((cmd_r == bfe_pkg::CMD_QUERY) && !bit_set)) begin
          state_nxt = bfe_pkg::ST_DONE;
        end else begin
          state_nxt = bfe_pkg::ST_PREP;
        end
      end
      bfe_pkg::ST_SWEEP: begin
        if (sw_addr_r == AW'(WORDS - 1)) state_nxt = bfe_pkg::ST_DONE;
      end
      bfe_pkg::ST_DONE: begin
        if (out_free) state_nxt = bfe_pkg::ST_IDLE;
      end
      default: state_nxt = bfe_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_addr;
    mem_wdata = rdata_r | (64'd1 << bit_pos);
    q_pop     = 1'b0;
    res_load  = 1'b0;
    unique case (state_r) inside
      bfe_pkg::ST_INIT_CLR, bfe_pkg::ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sw_addr_r;
        mem_wdata = '0;
      end
      bfe_pkg::ST_IDLE: q_pop = q_valid;
      bfe_pkg::ST_CHK:  mem_we = (cmd_r == bfe_pkg::CMD_ADD);
      bfe_pkg::ST_DONE: res_load = out_free;
      default: ;
    endcase
  end

  assign q_ready          = q_pop;
  assign status.init_busy = (state_r == bfe_pkg::ST_INIT_CLR);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfe_pkg::ST_INIT_CLR;
      sw_addr_r <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we && ((state_r == bfe_pkg::ST_INIT_CLR) ||
                     (state_r == bfe_pkg::ST_SWEEP))) begin
        sw_addr_r <= (sw_addr_r == AW'(WORDS - 1)) ? '0 : sw_addr_r + AW'(1);
      end
      // The count moves when the item starts.
      if (q_pop && (q_entry.cmd == bfe_pkg::CMD_ADD) && (cnt_r != '1)) begin
        cnt_r <= cnt_r + bfe_pkg::CNT_W'(1);
      end else if (q_pop && (q_entry.cmd == bfe_pkg::CMD_CLEAR)) begin
        cnt_r <= '0;
      end
      if (res_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= q_entry.cmd;
      base_r <= q_entry.base;
      salt_r <= '0;
      hidx_r <= '0;
      hit_r  <= (q_entry.cmd == bfe_pkg::CMD_QUERY);
    end
    unique case (state_r) inside
      bfe_pkg::ST_PREP: x_r <= salted ^ (salted >> bfe_pkg::MIX_SH_A);
      bfe_pkg::ST_M1L, bfe_pkg::ST_M2L: plo_r <= mul_p;
      bfe_pkg::ST_M1H, bfe_pkg::ST_M2H: x_r <= plo_r + {mul_p[31:0], 32'd0};
      bfe_pkg::ST_X13: x_r <= x_r ^ (x_r >> bfe_pkg::MIX_SH_B);
      bfe_pkg::ST_DLOAD: begin
        dq_r   <= x_r ^ (x_r >> bfe_pkg::MIX_SH_A);
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      bfe_pkg::ST_DIV: begin
        dq_r   <= dq_step;
        rem_r  <= rem_step;
        dcnt_r <= dcnt_r + DCW'(1);
      end
      bfe_pkg::ST_CHK: begin
        if ((cmd_r == bfe_pkg::CMD_QUERY) && !bit_set) hit_r <= 1'b0;
        salt_r <= salt_r + bfe_pkg::MIX_SALT;
        hidx_r <= hidx_r + KW'(1);
      end
      default: ;
    endcase
    if (res_load) begin
      out_hit_r <= hit_r;
      out_cnt_r <= cnt_r;
    end
  end

  // Bit store write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[word_addr];
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.might_contain = out_hit_r;
  assign out_ch.element_count = out_cnt_r;

  // No item leaves the queue while the store is swept after reset.
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfe_pkg::ST_INIT_CLR) |-> !q_pop)
    else $error("item taken during the reset sweep");

  // A clear holds the count at zero during its sweep.
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfe_pkg::ST_SWEEP) |-> (cnt_r == '0))
    else $error("count not zero during clear sweep");

  // The reduced position always lies below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfe_pkg::ST_RD) |-> (rem_r < n_use))
    else $error("remainder not below bit count");

  // Store writes come only from a sweep or from the check step of an add.
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == bfe_pkg::ST_CHK) && (cmd_r == bfe_pkg::CMD_ADD)) ||
               (state_r == bfe_pkg::ST_SWEEP) || (state_r == bfe_pkg::ST_INIT_CLR))
    else $error("unexpected store write");

endmodule

>>> hdl/bloom_filter_engine.sv
// Bloom filter engine. An add or query works through k hash positions, each mixed on one
// shared 32x32 multiplier, reduced by the divider, then read and checked in the bit store.
// A query stops at the first clear bit. Clear sweeps all WORDS words, WORDS = bits / 64 rounded up.
// Items run one at a time; a two-entry queue and an output register decouple the sides.
// After reset (synchronous, active low) the store is swept one word a cycle and no item
// is taken; configuration writes are taken at once.
module bloom_filter_engine #(
  parameter int unsigned BIT_CAPACITY = bfe_pkg::BIT_CAPACITY_DEF,
  parameter int unsigned MAX_HASHES   = bfe_pkg::MAX_HASHES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bfe_in_if.sink     in_ch,
  bfe_out_if.source  out_ch,
  bfe_cfg_if.sink    cfg_ch
);

  bfe_pkg::cfg_t          cfg_r;
  bfe_pkg::back_status_t  status;
  bfe_pkg::q_entry_t      q_entry;
  logic                   q_valid;
  logic                   q_ready;

  // Configuration registers, always writable.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_count  <= bfe_pkg::BIT_COUNT_RST;
      cfg_r.hash_count <= bfe_pkg::HASH_COUNT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        bfe_pkg::CFG_BIT_COUNT:  cfg_r.bit_count  <= cfg_ch.data;
        bfe_pkg::CFG_HASH_COUNT: cfg_r.hash_count <= cfg_ch.data[bfe_pkg::HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  bfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .status  (status),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  bfe_back #(
    .BIT_CAPACITY (BIT_CAPACITY),
    .MAX_HASHES   (MAX_HASHES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry),
    .status  (status),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the Bloom filter engine: directed and random items
// checked against a behavioral predictor. Depends on bfe_pkg and the channel interfaces.
module tb;

  localparam int unsigned STORE_BITS = 65536;
  localparam int unsigned HASH_LIMIT = 16;
  localparam longint unsigned CYCLE_LIMIT = 64'd8000000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned HOLD_OFF_CYCLES = 2000;
  // Opcode value with no defined operation.
  localparam logic [bfe_pkg::OPC_W-1:0] OPC_SPARE = 2'd3;

  typedef struct packed {
    logic [bfe_pkg::OPC_W-1:0]  opcode;
    logic [bfe_pkg::HASH_W-1:0] base_hash;
  } filter_item_t;

  typedef struct packed {
    logic                      might_contain;
    logic [bfe_pkg::CNT_W-1:0] element_count;
  } filter_answer_t;

  logic clk;
  logic rst_n;
  bfe_in_if  in_ch();
  bfe_out_if out_ch();
  bfe_cfg_if cfg_ch();

  bloom_filter_engine dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor state.
  bit                          model_store [STORE_BITS];
  logic [bfe_pkg::CNT_W-1:0]   model_count = '0;
  logic [bfe_pkg::BCNT_W-1:0]  model_bit_count = bfe_pkg::BIT_COUNT_RST;
  logic [bfe_pkg::HCNT_W-1:0]  model_hash_count = bfe_pkg::HASH_COUNT_RST;

  filter_item_t   pending_items[$];
  filter_answer_t expected_answers[$];

  int unsigned error_count = 0;
  int unsigned answers_seen = 0;
  int unsigned hits_seen = 0;
  longint unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;
  int unsigned hold_off_req = 0;
  int unsigned hold_off_ack;
  int unsigned offered_count = 0;
  int unsigned taken_count = 0;

  // Clock.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Derived 64-bit mix for hash position i.
  function automatic logic [63:0] mix64(input logic [63:0] base, input int unsigned i);
    logic [63:0] h;
    h = base ^ (64'(i) * bfe_pkg::MIX_SALT);
    h = h ^ (h >> bfe_pkg::MIX_SH_A);
    h = h * {32'd0, bfe_pkg::MIX_C1};
    h = h ^ (h >> bfe_pkg::MIX_SH_B);
    h = h * {32'd0, bfe_pkg::MIX_C2};
    h = h ^ (h >> bfe_pkg::MIX_SH_A);
    return h;
  endfunction

  // Update the predicted filter with one item and queue the answer it causes.
  task automatic predict_item(input filter_item_t it);
    logic [63:0] span;
    logic [63:0] pos;
    int unsigned k;
    logic hit;
    filter_answer_t ans;
    span = (model_bit_count == 0) ? 64'd1 :
           (model_bit_count > STORE_BITS) ? 64'(STORE_BITS) : 64'(model_bit_count);
    k = (model_hash_count > HASH_LIMIT) ? HASH_LIMIT : model_hash_count;
    hit = 1'b0;
    case (it.opcode)
      bfe_pkg::OPC_ADD: begin
        for (int unsigned i = 0; i < k; i++) begin
          pos = mix64(it.base_hash, i) % span;
          model_store[pos] = 1'b1;
        end
        if (model_count != '1) model_count++;
      end
      bfe_pkg::OPC_QUERY: begin
        hit = 1'b1;
        for (int unsigned i = 0; i < k; i++) begin
          pos = mix64(it.base_hash, i) % span;
          if (!model_store[pos]) hit = 1'b0;
        end
      end
      bfe_pkg::OPC_CLEAR: begin
        foreach (model_store[j]) model_store[j] = 1'b0;
        model_count = '0;
      end
      default: begin
      end
    endcase
    ans.might_contain = hit;
    ans.element_count = model_count;
    expected_answers.insert(expected_answers.size(), ans);
  endtask

  // Driver: offers queued items, idling at random. An offered item is held
  // until the acceptance process has counted it as taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && (taken_count != offered_count)) begin
      // Hold the offered item until taken.
    end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_ch.valid     <= 1'b1;
      in_ch.opcode    <= pending_items[0].opcode;
      in_ch.base_hash <= pending_items[0].base_hash;
      offered_count++;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Acceptance on the input side feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      taken_count++;
      predict_item(pending_items.pop_front());
    end
  end

  // Receiver readiness with random stalls and an occasional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_off_left = 0;
      hold_off_ack = hold_off_req;
    end else if (hold_off_req != hold_off_ack) begin
      hold_off_ack = hold_off_req;
      hold_off_left = HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each accepted answer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected answer: might_contain=%0b element_count=%0d",
               out_ch.might_contain, out_ch.element_count);
        error_count++;
      end else begin
        filter_answer_t exp_ans;
        exp_ans = expected_answers.pop_front();
        if (out_ch.might_contain !== exp_ans.might_contain) begin
          $error("might_contain: expected %0b, actual %0b",
                 exp_ans.might_contain, out_ch.might_contain);
          error_count++;
        end
        if (out_ch.element_count !== exp_ans.element_count) begin
          $error("element_count: expected %0d, actual %0d",
                 exp_ans.element_count, out_ch.element_count);
          error_count++;
        end
        answers_seen++;
        if (exp_ans.might_contain) hits_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Write one register, then mirror it in the predictor.
  task automatic write_reg(input logic [bfe_pkg::CIDX_W-1:0] idx,
                           input logic [bfe_pkg::CDATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == bfe_pkg::CFG_BIT_COUNT) model_bit_count = val;
    else model_hash_count = val[bfe_pkg::HCNT_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until all queued items are taken and all answers are in, then let the
  // engine settle before a register write.
  task automatic drain_items();
    while (pending_items.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_item(input logic [bfe_pkg::OPC_W-1:0] op, input logic [63:0] h);
    filter_item_t it;
    it.opcode = op;
    it.base_hash = h;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Random phase: adds, queries of remembered and of random elements, spare opcodes and clears.
  task automatic random_phase(input int unsigned n, input int unsigned idle,
                              input int unsigned stall);
    logic [63:0] known[$];
    int unsigned r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        known.insert(known.size(), rand64());
        queue_item(bfe_pkg::OPC_ADD, known[$]);
      end else if (r < 70 && known.size() > 0) begin
        queue_item(bfe_pkg::OPC_QUERY, known[$urandom_range(known.size() - 1)]);
      end else if (r < 92) begin
        queue_item(bfe_pkg::OPC_QUERY, rand64());
      end else if (r < 96) begin
        queue_item(OPC_SPARE, rand64());
      end else begin
        queue_item(bfe_pkg::OPC_CLEAR, rand64());
        known.delete();
      end
    end
    drain_items();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: field extremes and every opcode.
    queue_item(bfe_pkg::OPC_QUERY, 64'd0);
    queue_item(bfe_pkg::OPC_ADD, 64'd0);
    queue_item(bfe_pkg::OPC_QUERY, 64'd0);
    queue_item(bfe_pkg::OPC_ADD, '1);
    queue_item(bfe_pkg::OPC_QUERY, '1);
    queue_item(bfe_pkg::OPC_QUERY, 64'h5555_5555_5555_5555);
    queue_item(OPC_SPARE, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_item(bfe_pkg::OPC_CLEAR, 64'd0);
    queue_item(bfe_pkg::OPC_QUERY, '1);
    drain_items();

    // Zero hashes: adds only count and queries answer one.
    write_reg(bfe_pkg::CFG_HASH_COUNT, 17'd0);
    queue_item(bfe_pkg::OPC_ADD, 64'd1);
    queue_item(bfe_pkg::OPC_QUERY, 64'd99);
    drain_items();
    // Oversized hash count and zero bit count (treated as one bit).
    write_reg(bfe_pkg::CFG_HASH_COUNT, 17'd31);
    write_reg(bfe_pkg::CFG_BIT_COUNT, 17'd0);
    queue_item(bfe_pkg::OPC_QUERY, 64'd7);
    queue_item(bfe_pkg::OPC_ADD, 64'd7);
    queue_item(bfe_pkg::OPC_QUERY, '1);
    queue_item(bfe_pkg::OPC_CLEAR, 64'd0);
    drain_items();
    // Oversized bit count, used as full capacity; resize with a clear.
    write_reg(bfe_pkg::CFG_BIT_COUNT, 17'h1FFFF);
    write_reg(bfe_pkg::CFG_HASH_COUNT, 17'd16);
    queue_item(bfe_pkg::OPC_CLEAR, 64'd0);
    queue_item(bfe_pkg::OPC_ADD, 64'h8000_0000_0000_0000);
    queue_item(bfe_pkg::OPC_QUERY, 64'h8000_0000_0000_0000);
    queue_item(bfe_pkg::OPC_QUERY, 64'h0000_0000_0000_0001);
    drain_items();

    // Random phases over several settings and idling patterns.
    write_reg(bfe_pkg::CFG_BIT_COUNT, 17'd64);
    write_reg(bfe_pkg::CFG_HASH_COUNT, 17'd2);
    random_phase(400, 0, 0);
    write_reg(bfe_pkg::CFG_BIT_COUNT, 17'd1);
    write_reg(bfe_pkg::CFG_HASH_COUNT, 17'd1);
    random_phase(200, 86, 0);
    write_reg(bfe_pkg::CFG_BIT_COUNT, 17'd777);
    write_reg(bfe_pkg::CFG_HASH_COUNT, 17'd4);
    random_phase(450, 0, 86);
    write_reg(bfe_pkg::CFG_BIT_COUNT, 17'd65536);
    write_reg(bfe_pkg::CFG_HASH_COUNT, 17'd3);
    random_phase(300, 32, 32);
    write_reg(bfe_pkg::CFG_BIT_COUNT, 17'd300);
    write_reg(bfe_pkg::CFG_HASH_COUNT, 17'd8);
    // Long receiver hold-off so the engine fills and stalls its input.
    @(negedge clk);
    hold_off_req++;
    random_phase(580, 0, 10);

    // Finish: wait for every answer, then a short settle.
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d answers (%0d positive queries) over bit counts 0 to 131071,",
             answers_seen, hits_seen);
    $display("hash counts 0 to 31, all opcodes, idle and stall patterns and a long hold-off.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
